// ===== hw/rtl/pcc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the point/circle constrain block.
// ---------------------------------------------------------------------------
package pcc_pkg;

   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int DIFF_W   = COORD_W + 1;          // exact difference
   localparam int SUMSQ_W  = 2 * DIFF_W + 2;       // padded to an even width
   localparam int ROOT_W   = SUMSQ_W / 2;
   localparam int PROD_W   = DIFF_W + RADIUS_W;    // |d| * r
   localparam int QUOT_W   = 35;                   // quotient bits kept
   localparam int QDEPTH   = 8;                    // front to back queue depth
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = QUOT_W;

   localparam logic OP_LOCK = 1'b0;
   localparam logic OP_BUMP = 1'b1;

   // one classified word handed from the front to the back
   typedef struct packed {
      logic                      move;
      logic                      degen;
      logic                      neg_x;
      logic                      neg_y;
      logic [DIFF_W-1:0]         abs_x;
      logic [DIFF_W-1:0]         abs_y;
      logic [COORD_W-1:0]        cx;
      logic [COORD_W-1:0]        cy;
      logic [COORD_W-1:0]        px;
      logic [COORD_W-1:0]        py;
      logic [RADIUS_W-1:0]       radius;
      logic [SUMSQ_W-1:0]        sumsq;
   } pcc_item_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pcc_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcc_front
// Takes requests, forms the offset from the center, squares it and decides
// whether the point moves.
// ---------------------------------------------------------------------------
module pcc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           req_operation,
   input  wire logic [pcc_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic [pcc_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic [pcc_pkg::COORD_W-1:0]    req_center_x,
   input  wire logic [pcc_pkg::COORD_W-1:0]    req_center_y,
   input  wire logic [pcc_pkg::RADIUS_W-1:0]   req_circle_radius,
   output      logic                           push,
   output      pcc_pkg::pcc_item_type          push_item
);
   import pcc_pkg::*;

   // stage 1: differences
   logic                  v1_ff, op1_ff;
   logic [DIFF_W-1:0]     dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [COORD_W-1:0]    px1_ff, py1_ff, cx1_ff, cy1_ff;
   logic [RADIUS_W-1:0]   r1_ff;
   // stage 2: squares
   logic                  v2_ff, op2_ff, nx2_ff, ny2_ff;
   logic [DIFF_W-1:0]     ax2_ff, ay2_ff, ax2_in, ay2_in;
   logic [2*DIFF_W-1:0]   sqx2_ff, sqy2_ff;
   logic [2*RADIUS_W-1:0] rr2_ff;
   logic [COORD_W-1:0]    px2_ff, py2_ff, cx2_ff, cy2_ff;
   logic [RADIUS_W-1:0]   r2_ff;
   // stage 3: classify
   logic                  v3_ff;
   pcc_item_type          it3_ff, it3_in;
   logic [SUMSQ_W-1:0]    s_sum;
   logic                  go, zero;

   assign dx1_in = {req_point_x[COORD_W-1], req_point_x}
                 - {req_center_x[COORD_W-1], req_center_x};
   assign dy1_in = {req_point_y[COORD_W-1], req_point_y}
                 - {req_center_y[COORD_W-1], req_center_y};
   assign ax2_in = dx1_ff[DIFF_W-1] ? (~dx1_ff + DIFF_W'(1)) : dx1_ff;
   assign ay2_in = dy1_ff[DIFF_W-1] ? (~dy1_ff + DIFF_W'(1)) : dy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      op1_ff <= req_operation;
      dx1_ff <= dx1_in;
      dy1_ff <= dy1_in;
      px1_ff <= req_point_x;
      py1_ff <= req_point_y;
      cx1_ff <= req_center_x;
      cy1_ff <= req_center_y;
      r1_ff  <= req_circle_radius;

      op2_ff  <= op1_ff;
      nx2_ff  <= dx1_ff[DIFF_W-1];
      ny2_ff  <= dy1_ff[DIFF_W-1];
      ax2_ff  <= ax2_in;
      ay2_ff  <= ay2_in;
      sqx2_ff <= (2*DIFF_W)'(ax2_in) * (2*DIFF_W)'(ax2_in);
      sqy2_ff <= (2*DIFF_W)'(ay2_in) * (2*DIFF_W)'(ay2_in);
      rr2_ff  <= (2*RADIUS_W)'(r1_ff) * (2*RADIUS_W)'(r1_ff);
      px2_ff  <= px1_ff;
      py2_ff  <= py1_ff;
      cx2_ff  <= cx1_ff;
      cy2_ff  <= cy1_ff;
      r2_ff   <= r1_ff;

      it3_ff <= it3_in;
   end

   always_comb begin
      s_sum = SUMSQ_W'(sqx2_ff) + SUMSQ_W'(sqy2_ff);
      zero  = (s_sum == '0);
      go    = (op2_ff == OP_BUMP) ? (s_sum < SUMSQ_W'(rr2_ff))
                                  : (s_sum > SUMSQ_W'(rr2_ff));
      it3_in.move   = go && !zero;
      it3_in.degen  = go && zero;
      it3_in.neg_x  = nx2_ff;
      it3_in.neg_y  = ny2_ff;
      it3_in.abs_x  = ax2_ff;
      it3_in.abs_y  = ay2_ff;
      it3_in.cx     = cx2_ff;
      it3_in.cy     = cy2_ff;
      it3_in.px     = px2_ff;
      it3_in.py     = py2_ff;
      it3_in.radius = r2_ff;
      it3_in.sumsq  = s_sum;
   end

   assign push      = v3_ff;
   assign push_item = it3_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pcc_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcc_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module pcc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pcc_pkg::pcc_item_type push_item,
   input  wire logic                  pop,
   output      pcc_pkg::pcc_item_type pop_item,
   output      logic                  not_empty,
   output      logic [$clog2(pcc_pkg::QDEPTH):0] fill
);
   import pcc_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   pcc_item_type        mem_ff [QDEPTH];
   logic [PW-1:0]       wr_ff, rd_ff;
   logic [PW:0]         cnt_ff, cnt_in;
   logic                do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + (PW+1)'(1);
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign pop_item  = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign fill      = cnt_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pcc_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcc_div
// Pipelined restoring divider, one quotient bit per stage, with the
// quotient clamped to 2^(QUOT_W-1).
// ---------------------------------------------------------------------------
module pcc_div (
   input  wire logic                          clock,
   input  wire logic [pcc_pkg::PROD_W-1:0]    num,
   input  wire logic [pcc_pkg::ROOT_W-1:0]    den,
   output      logic [pcc_pkg::QUOT_W-1:0]    quot
);
   import pcc_pkg::*;

   localparam int HI_W = PROD_W - QUOT_W;
   localparam logic [QUOT_W-1:0] QCLAMP = {1'b1, {(QUOT_W-1){1'b0}}};

   logic [ROOT_W-1:0] rem_ff [DIV_STAGES+1];
   logic [QUOT_W-1:0] lo_ff  [DIV_STAGES+1];
   logic [QUOT_W-1:0] q_ff   [DIV_STAGES+1];
   logic [ROOT_W-1:0] den_ff [DIV_STAGES+1];
   logic              ovf_ff [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      rem_ff[0] <= ROOT_W'(num[PROD_W-1 -: HI_W]);
      lo_ff[0]  <= num[QUOT_W-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= den;
      // quotient would not fit the kept bits
      ovf_ff[0] <= ROOT_W'(num[PROD_W-1 -: HI_W]) >= den;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      logic [ROOT_W:0] trial;
      assign trial = {rem_ff[k], lo_ff[k][QUOT_W-1]};
      always_ff @(posedge clock) begin
         if (trial >= (ROOT_W+1)'(den_ff[k])) begin
            rem_ff[k+1] <= ROOT_W'(trial - (ROOT_W+1)'(den_ff[k]));
            q_ff[k+1]   <= {q_ff[k][QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff[k+1] <= ROOT_W'(trial);
            q_ff[k+1]   <= {q_ff[k][QUOT_W-2:0], 1'b0};
         end
         lo_ff[k+1]  <= {lo_ff[k][QUOT_W-2:0], 1'b0};
         den_ff[k+1] <= den_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign quot = (ovf_ff[DIV_STAGES] || q_ff[DIV_STAGES] > QCLAMP)
               ? QCLAMP : q_ff[DIV_STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/pcc_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcc_back
// Square root of the squared distance, scaling of the offset by
// radius / distance, and final placement with saturation.
// ---------------------------------------------------------------------------
module pcc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire pcc_pkg::pcc_item_type         in_item,
   output      logic                          out_valid,
   output      logic [pcc_pkg::COORD_W-1:0]   out_x,
   output      logic [pcc_pkg::COORD_W-1:0]   out_y,
   output      logic                          out_moved,
   output      logic                          out_degen
);
   import pcc_pkg::*;

   localparam int PL_W = QUOT_W + 2;
   localparam logic signed [PL_W-1:0] SMAX = PL_W'((64'(1) << (COORD_W-1)) - 64'(1));
   localparam logic signed [PL_W-1:0] SMIN = -(PL_W'(64'(1) << (COORD_W-1)));

   // square root pipeline, two radicand bits per stage
   logic              sq_v_ff    [SQRT_STAGES+1];
   pcc_item_type      sq_it_ff   [SQRT_STAGES+1];
   logic [SUMSQ_W-1:0] sq_s_ff   [SQRT_STAGES+1];
   logic [ROOT_W-1:0] sq_root_ff [SQRT_STAGES+1];
   logic [ROOT_W+1:0] sq_rem_ff  [SQRT_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else begin
         sq_v_ff[0] <= in_valid;
      end
      sq_it_ff[0]   <= in_item;
      sq_s_ff[0]    <= in_item.sumsq;
      sq_root_ff[0] <= '0;
      sq_rem_ff[0]  <= '0;
   end

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic [ROOT_W+3:0] tmp, trial;
      assign tmp   = {sq_rem_ff[k], sq_s_ff[k][SUMSQ_W-1 -: 2]};
      assign trial = (ROOT_W+4)'({sq_root_ff[k], 2'b01});
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         sq_it_ff[k+1] <= sq_it_ff[k];
         sq_s_ff[k+1]  <= {sq_s_ff[k][SUMSQ_W-3:0], 2'b00};
         if (tmp >= trial) begin
            sq_rem_ff[k+1]  <= (ROOT_W+2)'(tmp - trial);
            sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_ff[k+1]  <= (ROOT_W+2)'(tmp);
            sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // offset times radius
   logic              mu_v_ff;
   pcc_item_type      mu_it_ff;
   logic [PROD_W-1:0] mu_nx_ff, mu_ny_ff;
   logic [ROOT_W-1:0] mu_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_v_ff <= 1'b0;
      end else begin
         mu_v_ff <= sq_v_ff[SQRT_STAGES];
      end
      mu_it_ff  <= sq_it_ff[SQRT_STAGES];
      mu_nx_ff  <= PROD_W'(sq_it_ff[SQRT_STAGES].abs_x)
                 * PROD_W'(sq_it_ff[SQRT_STAGES].radius);
      mu_ny_ff  <= PROD_W'(sq_it_ff[SQRT_STAGES].abs_y)
                 * PROD_W'(sq_it_ff[SQRT_STAGES].radius);
      // dist is zero only when the point sits on the center; guard the divider
      mu_den_ff <= (sq_root_ff[SQRT_STAGES] == '0) ? ROOT_W'(1)
                                                   : sq_root_ff[SQRT_STAGES];
   end

   logic [QUOT_W-1:0] qx, qy;

   pcc_div u_div_x (.clock(clock), .num(mu_nx_ff), .den(mu_den_ff), .quot(qx));
   pcc_div u_div_y (.clock(clock), .num(mu_ny_ff), .den(mu_den_ff), .quot(qy));

   // item travels beside the dividers
   logic         dl_v_ff  [DIV_STAGES+1];
   pcc_item_type dl_it_ff [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_v_ff[0] <= 1'b0;
      end else begin
         dl_v_ff[0] <= mu_v_ff;
      end
      dl_it_ff[0] <= mu_it_ff;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dl_v_ff[k+1] <= 1'b0;
         end else begin
            dl_v_ff[k+1] <= dl_v_ff[k];
         end
         dl_it_ff[k+1] <= dl_it_ff[k];
      end
   end

   function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] c,
                                                input logic neg,
                                                input logic [QUOT_W-1:0] q);
      logic signed [PL_W-1:0] cs, v;
      cs = PL_W'($signed(c));
      v  = neg ? (cs - $signed(PL_W'(q))) : (cs + $signed(PL_W'(q)));
      if (v > SMAX) begin
         v = SMAX;
      end else if (v < SMIN) begin
         v = SMIN;
      end
      return v[COORD_W-1:0];
   endfunction

   logic                out_v_ff, out_m_ff, out_d_ff;
   logic [COORD_W-1:0]  out_x_ff, out_y_ff, out_x_in, out_y_in;
   pcc_item_type        fin;

   assign fin = dl_it_ff[DIV_STAGES];

   always_comb begin
      out_x_in = fin.px;
      out_y_in = fin.py;
      if (fin.move) begin
         out_x_in = place(fin.cx, fin.neg_x, qx);
         out_y_in = place(fin.cy, fin.neg_y, qy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dl_v_ff[DIV_STAGES];
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_m_ff <= fin.move;
      out_d_ff <= fin.degen;
   end

   assign out_valid = out_v_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_moved = out_m_ff;
   assign out_degen = out_d_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/point_circle_constrain.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// point_circle_constrain
// Keeps a fixed point position inside (lock) or outside (bump) a circle.
// ---------------------------------------------------------------------------
// Usage:
//   A request word (mode, point, center, radius) is taken on a rising edge
//   with start high and busy low. Each result word shows on the rsp_ ports
//   for one cycle with rsp_valid high; results come out in request order.
//   Throughput: one request per cycle, sustained.
//   From the accepting edge to the rsp_valid cycle a word passes
//   3 front stages (difference, squares, compare), 1 queue slot, an input
//   register and 34 square root stages (two radicand bits each), 1 multiply
//   stage, an input register and 35 divider stages (one quotient bit each)
//   and the output register.
//   The back never stalls and the receiver cannot hold results off, so the
//   queue holds at most one word; busy rises only at QDEPTH - 3 words.
//   Reset clears all valid bits and the queue; nothing is in flight after.
//   Moved points are placed at center + d * radius / floor(sqrt(|d|^2)),
//   truncated toward zero and saturated to the 32 bit range.
// ---------------------------------------------------------------------------
module point_circle_constrain (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_operation,
   input  wire logic [pcc_pkg::COORD_W-1:0]   req_point_x,
   input  wire logic [pcc_pkg::COORD_W-1:0]   req_point_y,
   input  wire logic [pcc_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic [pcc_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic [pcc_pkg::RADIUS_W-1:0]  req_circle_radius,
   output      logic                          rsp_valid,
   output      logic [pcc_pkg::COORD_W-1:0]   rsp_new_x,
   output      logic [pcc_pkg::COORD_W-1:0]   rsp_new_y,
   output      logic                          rsp_moved,
   output      logic                          rsp_degenerate
);
   import pcc_pkg::*;

   localparam int FW = $clog2(QDEPTH) + 1;

   logic          accept, push, q_ne;
   pcc_item_type  push_item, pop_item;
   logic [FW-1:0] fill;

   // leave room for the words already inside the front stages
   assign busy   = (fill >= FW'(QDEPTH - 3));
   assign accept = start && !busy;

   pcc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_operation     (req_operation),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_circle_radius (req_circle_radius),
      .push              (push),
      .push_item         (push_item)
   );

   pcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_ne),
      .pop_item  (pop_item),
      .not_empty (q_ne),
      .fill      (fill)
   );

   pcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_ne),
      .in_item   (pop_item),
      .out_valid (rsp_valid),
      .out_x     (rsp_new_x),
      .out_y     (rsp_new_y),
      .out_moved (rsp_moved),
      .out_degen (rsp_degenerate)
   );

endmodule
`default_nettype wire
